@@ rtl/core/ira_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ira_pkg;

  // Line phase codes
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_ST_A   = 4'd1;
  localparam logic [3:0] PH_ST_B   = 4'd2;
  localparam logic [3:0] PH_ST_C   = 4'd3;
  localparam logic [3:0] PH_WR_LO  = 4'd4;
  localparam logic [3:0] PH_WR_HI  = 4'd5;
  localparam logic [3:0] PH_ACK_LO = 4'd6;
  localparam logic [3:0] PH_ACK_HI = 4'd7;
  localparam logic [3:0] PH_RD_LO  = 4'd8;
  localparam logic [3:0] PH_RD_HI  = 4'd9;
  localparam logic [3:0] PH_NK_LO  = 4'd10;
  localparam logic [3:0] PH_NK_HI  = 4'd11;
  localparam logic [3:0] PH_SP_A   = 4'd12;
  localparam logic [3:0] PH_SP_B   = 4'd13;
  localparam logic [3:0] PH_SP_C   = 4'd14;

  // Transfer index within a transaction
  localparam logic [1:0] BYTE_ADDR_W = 2'd0;
  localparam logic [1:0] BYTE_REG    = 2'd1;
  localparam logic [1:0] BYTE_DATA   = 2'd2;
  localparam logic [1:0] BYTE_READ   = 2'd3;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_READ  = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd104;
  localparam logic [7:0] ADDR_BYTE_MASK       = 8'hFE;
  localparam logic [7:0] BIT_MSB              = 8'h80;
  localparam logic [2:0] LAST_BIT             = 3'd7;

  typedef struct packed {
    logic       start_command;
    logic       opcode;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/ira_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ira_cmd_if;
  logic       valid;
  logic       ready;
  logic       start_command;
  logic       opcode;
  logic [7:0] register_address;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (
    output valid, start_command, opcode, register_address, write_data, sda_in,
    input  ready
  );
  modport sink (
    input  valid, start_command, opcode, register_address, write_data, sda_in,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/ira_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ira_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;

  modport source (
    output valid, scl, sda_release, busy_res, done_res, read_data,
    input  ready
  );
  modport sink (
    input  valid, scl, sda_release, busy_res, done_res, read_data,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/ira_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ira_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] device_address;

  modport source (
    output valid, device_address,
    input  ready
  );
  modport sink (
    input  valid, device_address,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/ira_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bus sequencer: one line phase per enabled cycle
module ira_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step_en,
  input  wire ira_pkg::cmd_t cmd,
  input  wire logic [6:0]    device_address,
  output ira_pkg::res_t      res
);

  logic [3:0] phase,         phase_next;
  logic [2:0] bit_index,     bit_index_next;
  logic [1:0] byte_index,    byte_index_next;
  logic [7:0] shift_byte,    shift_byte_next;
  logic [7:0] received_byte, received_byte_next;
  logic       held_opcode,   held_opcode_next;
  logic [7:0] held_register, held_register_next;
  logic [7:0] held_data,     held_data_next;
  logic       scl_level,     scl_level_next;
  logic       sda_level,     sda_level_next;
  logic       done;
  logic       cur_bit;
  logic [7:0] addr_byte;

  assign cur_bit   = |(shift_byte & (ira_pkg::BIT_MSB >> bit_index));
  assign addr_byte = {device_address, 1'b0} & ira_pkg::ADDR_BYTE_MASK;

  // Next state for one word
  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    byte_index_next    = byte_index;
    shift_byte_next    = shift_byte;
    received_byte_next = received_byte;
    held_opcode_next   = held_opcode;
    held_register_next = held_register;
    held_data_next     = held_data;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    done               = 1'b0;

    // command taken only when idle; its tick already drives the first start phase
    if (phase == ira_pkg::PH_IDLE && cmd.start_command) begin
      held_opcode_next   = cmd.opcode;
      held_register_next = cmd.register_address;
      held_data_next     = cmd.write_data;
      byte_index_next    = ira_pkg::BYTE_ADDR_W;
      bit_index_next     = 3'd0;
      phase_next         = ira_pkg::PH_ST_A;
    end

    unique case (phase_next)
      ira_pkg::PH_ST_A: begin
        scl_level_next = 1'b0; sda_level_next = 1'b1;
        phase_next = ira_pkg::PH_ST_B;
      end
      ira_pkg::PH_ST_B: begin
        scl_level_next = 1'b1; sda_level_next = 1'b1;
        phase_next = ira_pkg::PH_ST_C;
      end
      ira_pkg::PH_ST_C: begin
        scl_level_next  = 1'b1; sda_level_next = 1'b0;
        shift_byte_next = (byte_index == ira_pkg::BYTE_ADDR_W) ? addr_byte
                                                              : (addr_byte | 8'h01);
        bit_index_next  = 3'd0;
        phase_next      = ira_pkg::PH_WR_LO;
      end
      ira_pkg::PH_WR_LO: begin
        scl_level_next = 1'b0; sda_level_next = cur_bit;
        phase_next = ira_pkg::PH_WR_HI;
      end
      ira_pkg::PH_WR_HI: begin
        scl_level_next = 1'b1; sda_level_next = cur_bit;
        if (bit_index == ira_pkg::LAST_BIT) begin
          phase_next = ira_pkg::PH_ACK_LO;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = ira_pkg::PH_WR_LO;
        end
      end
      ira_pkg::PH_ACK_LO: begin
        scl_level_next = 1'b0; sda_level_next = 1'b1;
        phase_next = ira_pkg::PH_ACK_HI;
      end
      ira_pkg::PH_ACK_HI: begin
        scl_level_next = 1'b1; sda_level_next = 1'b1;
        // hold here until the target pulls SDA low
        if (!cmd.sda_in) begin
          priority if (byte_index == ira_pkg::BYTE_ADDR_W) begin
            byte_index_next = ira_pkg::BYTE_REG;
            shift_byte_next = held_register;
            bit_index_next  = 3'd0;
            phase_next      = ira_pkg::PH_WR_LO;
          end else if (byte_index == ira_pkg::BYTE_REG) begin
            byte_index_next = ira_pkg::BYTE_DATA;
            if (held_opcode == ira_pkg::OP_READ) begin
              phase_next = ira_pkg::PH_ST_A;
            end else begin
              shift_byte_next = held_data;
              bit_index_next  = 3'd0;
              phase_next      = ira_pkg::PH_WR_LO;
            end
          end else if (byte_index == ira_pkg::BYTE_DATA &&
                       held_opcode == ira_pkg::OP_READ) begin
            byte_index_next = ira_pkg::BYTE_READ;
            bit_index_next  = 3'd0;
            shift_byte_next = 8'd0;
            phase_next      = ira_pkg::PH_RD_LO;
          end else begin
            phase_next = ira_pkg::PH_SP_A;
          end
        end
      end
      ira_pkg::PH_RD_LO: begin
        scl_level_next = 1'b0; sda_level_next = 1'b1;
        phase_next = ira_pkg::PH_RD_HI;
      end
      ira_pkg::PH_RD_HI: begin
        scl_level_next  = 1'b1; sda_level_next = 1'b1;
        shift_byte_next = {shift_byte[6:0], cmd.sda_in};
        if (bit_index == ira_pkg::LAST_BIT) begin
          phase_next = ira_pkg::PH_NK_LO;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = ira_pkg::PH_RD_LO;
        end
      end
      ira_pkg::PH_NK_LO: begin
        scl_level_next = 1'b0; sda_level_next = 1'b1;
        phase_next = ira_pkg::PH_NK_HI;
      end
      ira_pkg::PH_NK_HI: begin
        scl_level_next = 1'b1; sda_level_next = 1'b1;
        phase_next = ira_pkg::PH_SP_A;
      end
      ira_pkg::PH_SP_A: begin
        scl_level_next = 1'b0; sda_level_next = 1'b0;
        phase_next = ira_pkg::PH_SP_B;
      end
      ira_pkg::PH_SP_B: begin
        scl_level_next = 1'b1; sda_level_next = 1'b0;
        phase_next = ira_pkg::PH_SP_C;
      end
      ira_pkg::PH_SP_C: begin
        scl_level_next = 1'b1; sda_level_next = 1'b1;
        if (held_opcode == ira_pkg::OP_READ) begin
          received_byte_next = shift_byte;
        end
        done       = 1'b1;
        phase_next = ira_pkg::PH_IDLE;
      end
      ira_pkg::PH_IDLE: begin
        phase_next = ira_pkg::PH_IDLE;
      end
      default: begin
        phase_next = ira_pkg::PH_IDLE;
      end
    endcase
  end

  // Result of this word's phase
  always_comb begin
    res.scl         = scl_level_next;
    res.sda_release = sda_level_next;
    res.busy_res    = (phase != ira_pkg::PH_IDLE) || cmd.start_command;
    res.done_res    = done;
    res.read_data   = received_byte_next;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ira_pkg::PH_IDLE;
      bit_index     <= 3'd0;
      byte_index    <= ira_pkg::BYTE_ADDR_W;
      shift_byte    <= 8'd0;
      received_byte <= 8'd0;
      held_opcode   <= ira_pkg::OP_WRITE;
      held_register <= 8'd0;
      held_data     <= 8'd0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
    end else if (step_en) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      byte_index    <= byte_index_next;
      shift_byte    <= shift_byte_next;
      received_byte <= received_byte_next;
      held_opcode   <= held_opcode_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/i2c_register_access_master.sv @@
`timescale 1ns / 1ps
`default_nettype none

// I2C register read/write master, one bus line phase per input word.
// cmd: one word per tick: sampled SDA plus an optional command (start_command,
//   opcode 0 write / 1 read, register_address, write_data). A command is taken
//   only while the sequencer is idle; otherwise its fields are ignored.
// res: exactly one word per cmd word: SCL and SDA levels to drive, busy_res,
//   done_res on the stop tick, and the byte from the last completed read.
// cfg: 7-bit device address, always ready; write it only while idle.
// Path: a cmd word is held in the input register, stepped through the
//   sequencer when the result register can take it, and then presented on
//   res from the result register.
// Throughput: one word per cycle while res is not held; the input and result
//   registers keep both sides moving, and the phase step sets the rate.
// Stall: while res is held, the sequencer does not step and the input register
//   keeps one word; cmd.ready drops only when both registers are full.
// Reset: lines released (SCL and SDA high), sequencer idle, read byte zero,
//   device address 104, both channels empty.
module i2c_register_access_master (
  input  wire logic clk,
  input  wire logic rst,
  ira_cmd_if.sink   cmd,
  ira_res_if.source res,
  ira_cfg_if.sink   cfg
);

  logic          cmd_valid_q;
  ira_pkg::cmd_t cmd_q;
  logic          res_valid_q;
  ira_pkg::res_t res_q;
  ira_pkg::res_t step_res;
  logic [6:0]    device_address;
  logic          advance;

  assign advance   = cmd_valid_q && (!res_valid_q || res.ready);
  assign cmd.ready = !cmd_valid_q || advance;
  assign cfg.ready = 1'b1;

  // Device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ira_pkg::DEVICE_ADDRESS_RESET;
    end else if (cfg.valid) begin
      device_address <= cfg.device_address;
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid_q <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q.start_command    <= cmd.start_command;
      cmd_q.opcode           <= cmd.opcode;
      cmd_q.register_address <= cmd.register_address;
      cmd_q.write_data       <= cmd.write_data;
      cmd_q.sda_in           <= cmd.sda_in;
    end
  end

  ira_step u_step (
    .clk            (clk),
    .rst            (rst),
    .step_en        (advance),
    .cmd            (cmd_q),
    .device_address (device_address),
    .res            (step_res)
  );

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res.ready) begin
      res_valid_q <= cmd_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign res.valid       = res_valid_q;
  assign res.scl         = res_q.scl;
  assign res.sda_release = res_q.sda_release;
  assign res.busy_res    = res_q.busy_res;
  assign res.done_res    = res_q.done_res;
  assign res.read_data   = res_q.read_data;

  // A stepped word always lands in the result register
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid_q)
    else $error("stepped word not presented on res");

  // Input register never overwritten while it holds an unstepped word
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid_q && !advance) |-> !cmd.ready)
    else $error("input register overrun");

  // Stop completes only inside a transaction, with both lines released
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.done_res) |-> (res.busy_res && res.scl && res.sda_release))
    else $error("done without a completed stop");

  // Idle words repeat the line levels of the previous word
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid_q && !step_res.busy_res) |->
      (step_res.scl == res_q.scl && step_res.sda_release == res_q.sda_release))
    else $error("line levels moved while idle");

endmodule

`default_nettype wire
